>>> hw/rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg: shared types for the grid ray coverage counter
// Opcodes, register indexes, item and command records, queue status.
// ----------------------------------------------------------------------------
package grc_pkg;

	// linear index width: covers y * width + x for any 11-bit register pattern
	localparam int IDX_W = 22;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_PROBE = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CFG_GRID_WIDTH  = 2'd0,
		CFG_GRID_HEIGHT = 2'd1,
		CFG_CELL_COUNT  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CLS_FREE_PERIM = 2'd0,
		CLS_OCC_PERIM  = 2'd1,
		CLS_TARGET     = 2'd2,
		CLS_BLOCKING   = 2'd3
	} cell_cls_t;

	typedef enum logic {
		B_IDLE = 1'b0,
		B_EXEC = 1'b1
	} back_state_t;

	typedef struct packed {
		logic [10:0] grid_width;
		logic [10:0] grid_height;
		logic [16:0] cell_count;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] cell_index;
		logic [1:0]  cell_class;
		logic        cell_covered;
		logic [9:0]  sensor_x;
		logic [9:0]  sensor_y;
		logic [9:0]  offset_x;
		logic [9:0]  offset_y;
		logic        ray_last;
		logic        sweep_last;
		logic        commit;
		logic [15:0] site_id;
	} item_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] idx;
		logic             oob;
		logic [15:0]      cell_index;
		logic [1:0]       cell_class;
		logic             cell_covered;
		logic             ray_last;
		logic             sweep_last;
		logic             commit;
		logic [15:0]      site_id;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> hw/rtl/grc_front.sv
// ----------------------------------------------------------------------------
// grc_front: input stage and ray cell classification
// Stage 1 forms cell coordinates and checks grid bounds, stage 2 forms the
// linear index and checks it against the store depth.
// ----------------------------------------------------------------------------
module grc_front import grc_pkg::*; #(
	parameter int GRID_CELLS = 65536
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  item_t   item,
	input  q_stat_t qstat,
	output logic    push,
	output cmd_t    push_cmd
);

	localparam logic [IDX_W-1:0] CELLS_L = IDX_W'(GRID_CELLS);

	logic        v_s1, v_s2;
	logic        rdy_s1, rdy_s2;
	item_t       item_s1;
	logic [10:0] x_s1, y_s1;
	logic        oob_s1;
	cmd_t        cmd_s2;

	logic signed [11:0] x_full, y_full;
	logic               oob_now;
	logic [IDX_W-1:0]   prod, idx_now;

	// signed add of sensor position and offset
	assign x_full = $signed({2'b00, item.sensor_x})
		+ $signed({{2{item.offset_x[9]}}, item.offset_x});
	assign y_full = $signed({2'b00, item.sensor_y})
		+ $signed({{2{item.offset_y[9]}}, item.offset_y});

	assign oob_now = x_full[11] || y_full[11]
		|| (x_full[10:0] >= cfg.grid_width)
		|| (y_full[10:0] >= cfg.grid_height);

	assign prod    = IDX_W'(y_s1) * IDX_W'(cfg.grid_width);
	assign idx_now = prod + IDX_W'(x_s1);

	assign push   = v_s2 && !qstat.full;
	assign rdy_s2 = !v_s2 || !qstat.full;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign push_cmd = cmd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= in_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			item_s1 <= item;
			x_s1    <= x_full[10:0];
			y_s1    <= y_full[10:0];
			oob_s1  <= oob_now;
		end
		if (rdy_s2 && v_s1) begin
			cmd_s2.op           <= item_s1.op;
			cmd_s2.idx          <= idx_now;
			cmd_s2.oob          <= oob_s1 || (idx_now >= CELLS_L);
			cmd_s2.cell_index   <= item_s1.cell_index;
			cmd_s2.cell_class   <= item_s1.cell_class;
			cmd_s2.cell_covered <= item_s1.cell_covered;
			cmd_s2.ray_last     <= item_s1.ray_last;
			cmd_s2.sweep_last   <= item_s1.sweep_last;
			cmd_s2.commit       <= item_s1.commit;
			cmd_s2.site_id      <= item_s1.site_id;
		end
	end

endmodule

>>> hw/rtl/grc_queue.sv
// ----------------------------------------------------------------------------
// grc_queue: command queue between front and back
// Small circular buffer; lets either side stall on its own.
// ----------------------------------------------------------------------------
module grc_queue import grc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t qstat
);

	cmd_t              buf_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign head        = buf_q[rp_q];
	assign qstat.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + QPTR_W'(1);
			if (pop)
				rp_q <= rp_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= push_cmd;
	end

endmodule

>>> hw/rtl/grc_back.sv
// ----------------------------------------------------------------------------
// grc_back: grid store, sweep counters and result register
// Reads the cell record, applies one command, writes back covered marks or a written cell record.
// ----------------------------------------------------------------------------
module grc_back import grc_pkg::*; #(
	parameter int GRID_CELLS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        head,
	input  q_stat_t     qstat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] sweep_count,
	output logic        sweep_done,
	output logic        improved,
	output logic [15:0] best_count,
	output logic [15:0] best_point,
	output logic [16:0] covered_total
);

	localparam int ADDR_W = $clog2(GRID_CELLS);
	localparam logic [IDX_W-1:0] CELLS_L = IDX_W'(GRID_CELLS);

	// cell record: class in [2:1], covered mark in [0]
	logic [2:0] mem [GRID_CELLS];
	logic [2:0] rd_q;

	back_state_t state_q, state_d;
	cmd_t        cmd_q;
	logic        exec_go;

	logic        ray_blocked_q;
	logic [15:0] run_q, best_q, pos_q;
	logic [16:0] total_q;

	logic        blk_d;
	logic [15:0] run_d, best_d, pos_d, shown_d;
	logic [16:0] total_d;
	logic        done_d, impr_d;
	logic        we_d;
	logic [ADDR_W-1:0] wa_d;
	logic [2:0]  wd_d;

	logic [IDX_W-1:0] wr_idx;
	logic      in_cells, cell_blk, new_target;
	cell_cls_t cls;
	logic [15:0] run_inc;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: if (!qstat.empty) state_d = B_EXEC;
			B_EXEC: if (out_ready || !out_valid) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop     = 1'b0;
		exec_go = 1'b0;
		case (state_q)
			B_IDLE: pop = !qstat.empty;
			B_EXEC: exec_go = out_ready || !out_valid;
			default: ;
		endcase
	end

	assign wr_idx     = IDX_W'(cmd_q.cell_index);
	assign cls        = cell_cls_t'(rd_q[2:1]);
	assign in_cells   = !cmd_q.oob && (cmd_q.idx < IDX_W'(cfg.cell_count));
	assign cell_blk   = !in_cells || (cls == CLS_OCC_PERIM) || (cls == CLS_BLOCKING);
	assign new_target = in_cells && (cls == CLS_TARGET) && !rd_q[0];
	assign run_inc    = (run_q != 16'hFFFF) ? run_q + 16'd1 : run_q;

	// command execution
	always_comb begin
		blk_d   = ray_blocked_q;
		run_d   = run_q;
		best_d  = best_q;
		pos_d   = pos_q;
		total_d = total_q;
		shown_d = run_q;
		done_d  = 1'b0;
		impr_d  = 1'b0;
		we_d    = 1'b0;
		wa_d    = cmd_q.idx[ADDR_W-1:0];
		wd_d    = {rd_q[2:1], 1'b1};
		case (op_t'(cmd_q.op))
			OP_WRITE: begin
				wa_d = wr_idx[ADDR_W-1:0];
				wd_d = {cmd_q.cell_class, cmd_q.cell_covered};
				we_d = (wr_idx < CELLS_L);
			end
			OP_CLEAR: begin
				best_d = '0;
				pos_d  = '0;
			end
			OP_PROBE: begin
				if (!ray_blocked_q) begin
					blk_d = cell_blk;
					if (new_target) begin
						run_d = run_inc;
						if (cmd_q.commit) begin
							we_d = 1'b1;
							if (total_q != 17'h1FFFF)
								total_d = total_q + 17'd1;
						end
					end
				end
				if (cmd_q.ray_last)
					blk_d = 1'b0;
				shown_d = run_d;
				if (cmd_q.sweep_last) begin
					done_d = 1'b1;
					if (run_d > best_q) begin
						impr_d = 1'b1;
						best_d = run_d;
						pos_d  = cmd_q.site_id;
					end
					run_d = '0;
					blk_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop)
			rd_q <= mem[head.idx[ADDR_W-1:0]];
		if (exec_go && we_d)
			mem[wa_d] <= wd_d;
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= head;
		if (exec_go) begin
			sweep_count   <= shown_d;
			sweep_done    <= done_d;
			improved      <= impr_d;
			best_count    <= best_d;
			best_point    <= pos_d;
			covered_total <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			ray_blocked_q <= 1'b0;
			run_q         <= '0;
			best_q        <= '0;
			pos_q         <= '0;
			total_q       <= '0;
			out_valid     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_go) begin
				ray_blocked_q <= blk_d;
				run_q         <= run_d;
				best_q        <= best_d;
				pos_q         <= pos_d;
				total_q       <= total_d;
				out_valid     <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/grid_ray_coverage_counter_top.sv
// ----------------------------------------------------------------------------
// grid_ray_coverage_counter_top: occupancy grid ray coverage counter
// The back end takes one item at a time: a grid store read, then the update
//   (registered read, then write back), before the next item is popped.
// Reset: arst_n clears control, counters and best record; registers return
//   to width 256, height 256, cell count 65536. The grid store is not cleared.
// ----------------------------------------------------------------------------
module grid_ray_coverage_counter_top import grc_pkg::*; #(
	parameter int GRID_CELLS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [16:0] wr_data,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] cell_index,
	input  logic [1:0]  cell_class,
	input  logic        cell_covered,
	input  logic [9:0]  sensor_x,
	input  logic [9:0]  sensor_y,
	input  logic signed [9:0] offset_x,
	input  logic signed [9:0] offset_y,
	input  logic        ray_last,
	input  logic        sweep_last,
	input  logic        commit,
	input  logic [15:0] site_id,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] sweep_count,
	output logic        sweep_done,
	output logic        improved,
	output logic [15:0] best_count,
	output logic [15:0] best_point,
	output logic [16:0] covered_total
);

	cfg_t    cfg_q;
	item_t   item;
	cmd_t    push_cmd, head;
	logic    push, pop;
	q_stat_t qstat;

	// Registers are to be written only while idle (a rule for the user; the block does not
	// enforce it), so front and back may both read them directly without any shadowing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width  <= 11'd256;
			cfg_q.grid_height <= 11'd256;
			cfg_q.cell_count  <= 17'd65536;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_GRID_WIDTH:  cfg_q.grid_width  <= wr_data[10:0];
				CFG_GRID_HEIGHT: cfg_q.grid_height <= wr_data[10:0];
				CFG_CELL_COUNT:  cfg_q.cell_count  <= wr_data;
				default: ;
			endcase
		end
	end

	assign item.op           = op;
	assign item.cell_index   = cell_index;
	assign item.cell_class   = cell_class;
	assign item.cell_covered = cell_covered;
	assign item.sensor_x     = sensor_x;
	assign item.sensor_y     = sensor_y;
	assign item.offset_x     = offset_x;
	assign item.offset_y     = offset_y;
	assign item.ray_last     = ray_last;
	assign item.sweep_last   = sweep_last;
	assign item.commit       = commit;
	assign item.site_id      = site_id;

	// Front: two-stage coordinate and index computation; stalls only when
	// the queue is full.
	grc_front #(
		.GRID_CELLS(GRID_CELLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.qstat    (qstat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Queue decouples front transfers from back-end store accesses.
	grc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// Back: one command at a time; store read, then update and result load.
	// Result register lets the next command be popped while a result waits.
	grc_back #(
		.GRID_CELLS(GRID_CELLS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sweep_count   (sweep_count),
		.sweep_done    (sweep_done),
		.improved      (improved),
		.best_count    (best_count),
		.best_point    (best_point),
		.covered_total (covered_total)
	);

endmodule
